FILE: src/rpvs_pkg.sv
package rpvs_pkg;

    // Width of the per-bead micro-step counter.
    localparam int PH_W = 4;

    // Last micro-step of each sequence.
    localparam logic [PH_W-1:0] PH_SETUP_LAST = 4'd4;
    localparam logic [PH_W-1:0] PH_KICK_LAST  = 4'd3;
    localparam logic [PH_W-1:0] PH_DRIFT_LAST = 4'd8;
    localparam logic [PH_W-1:0] PH_FORCE_LAST = 4'd11;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [2:0] CFG_RING_FREQ   = 3'd1;
    localparam logic [2:0] CFG_MASS        = 3'd2;
    localparam logic [2:0] CFG_INV_MASS    = 3'd3;
    localparam logic [2:0] CFG_EXT_FREQ    = 3'd4;
    localparam logic [2:0] CFG_REST_POS    = 3'd5;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_PREP = 2'd1,
        ACT_STEP = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SETUP,
        S_KICK1,
        S_DRIFT,
        S_FORCE,
        S_KICK2,
        S_DONE
    } t_state;

    // Datapath micro-operations.
    typedef enum logic [4:0] {
        U_NOP,
        U_LOAD,
        U_SU_MKS,
        U_SU_MKE,
        U_SU_MDT,
        U_SU_KE,
        U_SU_DT2,
        U_KI_MUL,
        U_KI_WR,
        U_DR_MV,
        U_DR_MPP,
        U_DR_V,
        U_DR_MQ,
        U_DR_MY,
        U_DR_MH,
        U_DR_WR,
        U_DR_ACC,
        U_FO_RN,
        U_FO_RP,
        U_FO_LP,
        U_FO_LX,
        U_FO_MKD,
        U_FO_MKX,
        U_FO_KD,
        U_FO_KX,
        U_FO_MQ,
        U_FO_MH,
        U_FO_ACC,
        U_FO_WR
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic take;
        logic slot_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_slot;
    } t_stat;

endpackage

FILE: src/rpvs_ram.sv
module rpvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/rpvs_ctrl.sv
module rpvs_ctrl import rpvs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_cmd       o_cmd,
    input  t_stat      i_stat
);

    t_state          r_state, n_state;
    logic [PH_W-1:0] r_phase, n_phase;
    t_action         r_act, n_act;
    logic            r_ovalid, n_ovalid;
    t_uop            c_uop;
    logic            c_last;
    logic            c_take;
    logic            c_out_load;

    assign c_take     = (r_state == S_IDLE) && i_in_valid;
    assign c_out_load = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    // Micro-step table for each sequence.
    always_comb begin
        c_uop  = U_NOP;
        c_last = 1'b0;
        case (r_state)
            S_LOAD: begin
                c_uop  = U_LOAD;
                c_last = 1'b1;
            end
            S_SETUP: begin
                c_last = (r_phase == PH_SETUP_LAST);
                case (r_phase)
                    4'd0:    c_uop = U_SU_MKS;
                    4'd1:    c_uop = U_SU_MKE;
                    4'd2:    c_uop = U_SU_MDT;
                    4'd3:    c_uop = U_SU_KE;
                    4'd4:    c_uop = U_SU_DT2;
                    default: c_uop = U_NOP;
                endcase
            end
            S_KICK1, S_KICK2: begin
                c_last = (r_phase == PH_KICK_LAST);
                case (r_phase)
                    4'd1:    c_uop = U_KI_MUL;
                    4'd3:    c_uop = U_KI_WR;
                    default: c_uop = U_NOP;
                endcase
            end
            S_DRIFT: begin
                c_last = (r_phase == PH_DRIFT_LAST);
                case (r_phase)
                    4'd1:    c_uop = U_DR_MV;
                    4'd2:    c_uop = U_DR_MPP;
                    4'd3:    c_uop = U_DR_V;
                    4'd4:    c_uop = U_DR_MQ;
                    4'd5:    c_uop = U_DR_MY;
                    4'd6:    c_uop = U_DR_MH;
                    4'd7:    c_uop = U_DR_WR;
                    4'd8:    c_uop = U_DR_ACC;
                    default: c_uop = U_NOP;
                endcase
            end
            S_FORCE: begin
                c_last = (r_phase == PH_FORCE_LAST);
                case (r_phase)
                    4'd0:    c_uop = U_FO_RN;
                    4'd1:    c_uop = U_FO_RP;
                    4'd2:    c_uop = U_FO_LP;
                    4'd3:    c_uop = U_FO_LX;
                    4'd4:    c_uop = U_FO_MKD;
                    4'd5:    c_uop = U_FO_MKX;
                    4'd6:    c_uop = U_FO_KD;
                    4'd7:    c_uop = U_FO_KX;
                    4'd8:    c_uop = U_FO_MQ;
                    4'd9:    c_uop = U_FO_MH;
                    4'd10:   c_uop = U_FO_ACC;
                    4'd11:   c_uop = U_FO_WR;
                    default: c_uop = U_NOP;
                endcase
            end
            default: begin
                c_uop  = U_NOP;
                c_last = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        case (r_state)
            S_IDLE: begin
                if (c_take) begin
                    n_act = t_action'(i_action);
                    case (t_action'(i_action))
                        ACT_LOAD: n_state = S_LOAD;
                        ACT_PREP: n_state = S_SETUP;
                        ACT_STEP: n_state = S_SETUP;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD:  n_state = S_DONE;
            S_SETUP: begin
                if (c_last) begin
                    n_state = (r_act == ACT_STEP) ? S_KICK1 : S_FORCE;
                end
            end
            S_KICK1: begin
                if (c_last && i_stat.last_slot) begin
                    n_state = S_DRIFT;
                end
            end
            S_DRIFT: begin
                if (c_last && i_stat.last_slot) begin
                    n_state = S_FORCE;
                end
            end
            S_FORCE: begin
                if (c_last && i_stat.last_slot) begin
                    n_state = (r_act == ACT_STEP) ? S_KICK2 : S_DONE;
                end
            end
            S_KICK2: begin
                if (c_last && i_stat.last_slot) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (c_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // The micro-step counter only runs inside a sequence.
        if (n_state != r_state || c_last || r_state == S_IDLE || r_state == S_DONE) begin
            n_phase = '0;
        end else begin
            n_phase = r_phase + 4'd1;
        end

        if (c_out_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.uop      = c_uop;
        o_cmd.take     = c_take;
        o_cmd.out_load = c_out_load;
        o_cmd.slot_inc = c_last && (r_state == S_KICK1 || r_state == S_DRIFT ||
                                    r_state == S_FORCE || r_state == S_KICK2);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_act    <= ACT_NOP;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_act    <= n_act;
            r_ovalid <= n_ovalid;
        end
    end

    // A taken request closes the input until its result is queued.
    a_take_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input stayed open after a request was taken");

    // Queuing a result always raises the output valid.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("result queued without output valid");

    // The micro-step counter stays within the longest sequence.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_phase <= PH_FORCE_LAST))
        else $error("micro-step counter out of range");

    // The bead counter never moves while idle.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_cmd.slot_inc)
        else $error("bead counter moved while idle");

endmodule

FILE: src/rpvs_dpath.sv
module rpvs_dpath import rpvs_pkg::*; #(
    parameter int BEADS     = 32,
    parameter int DOFS      = 2,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_dof_index,
    input  logic [4:0]         i_bead_index,
    input  logic signed [31:0] i_load_position,
    input  logic signed [31:0] i_load_momentum,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [30:0]        o_kinetic_energy,
    output logic [30:0]        o_potential_energy,
    output logic [30:0]        o_total_energy,
    output logic signed [31:0] o_probe_position,
    output logic signed [31:0] o_probe_momentum
);

    localparam int NSLOTS = BEADS * DOFS;
    localparam int AW = $clog2(NSLOTS);
    localparam int BW = $clog2(BEADS);
    localparam int DW = (DOFS > 1) ? $clog2(DOFS) : 1;
    localparam logic [63:0] RND_ULP = 64'd1 << (FRAC_BITS - 1);
    localparam logic signed [31:0] C_HALF    = 32'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [31:0] C_QUARTER = 32'(64'd1 << (FRAC_BITS - 2));

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -35'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic [30:0] eadd(input logic [30:0] acc,
                                         input logic signed [31:0] term);
        logic [31:0] s;
        s = {1'b0, acc} + ((term > 32'sd0) ? {1'b0, term[30:0]} : 32'd0);
        return s[31] ? 31'h7fffffff : s[30:0];
    endfunction

    // Configuration registers.
    logic [16:0]        r_dt;
    logic [30:0]        r_wp2;
    logic [24:0]        r_m;
    logic [24:0]        r_inv;
    logic [30:0]        r_w2;
    logic signed [31:0] r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt  <= 17'd655;
            r_wp2 <= 31'd65536;
            r_m   <= 25'd131072;
            r_inv <= 25'd32768;
            r_w2  <= 31'd2048;
            r_req <= 32'sd152699;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TIME_STEP: r_dt  <= i_cfg_data[16:0];
                CFG_RING_FREQ: r_wp2 <= i_cfg_data[30:0];
                CFG_MASS:      r_m   <= i_cfg_data[24:0];
                CFG_INV_MASS:  r_inv <= i_cfg_data[24:0];
                CFG_EXT_FREQ:  r_w2  <= i_cfg_data[30:0];
                CFG_REST_POS:  r_req <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [31:0] c_dt, c_wp2, c_m, c_inv, c_w2;
    assign c_dt  = {15'd0, r_dt};
    assign c_wp2 = {1'b0, r_wp2};
    assign c_m   = {7'd0, r_m};
    assign c_inv = {7'd0, r_inv};
    assign c_w2  = {1'b0, r_w2};

    // Bead counter and addresses.
    logic [BW-1:0] r_bead;
    logic [DW-1:0] r_dof;
    logic [BW-1:0] c_bead_nx, c_bead_pv;
    logic [AW-1:0] c_cur, c_nx, c_pv;
    logic          c_bead_end, c_dof_end;

    assign c_bead_end = (r_bead == BW'(BEADS - 1));
    assign c_dof_end  = (r_dof == DW'(DOFS - 1));
    assign c_bead_nx  = c_bead_end ? '0 : r_bead + 1'b1;
    assign c_bead_pv  = (r_bead == '0) ? BW'(BEADS - 1) : r_bead - 1'b1;
    assign c_cur = AW'(32'(r_dof) * BEADS + 32'(r_bead));
    assign c_nx  = AW'(32'(r_dof) * BEADS + 32'(c_bead_nx));
    assign c_pv  = AW'(32'(r_dof) * BEADS + 32'(c_bead_pv));
    assign o_stat.last_slot = c_bead_end && c_dof_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.take) begin
            r_bead <= '0;
            r_dof  <= '0;
        end else if (i_cmd.slot_inc) begin
            r_bead <= c_bead_nx;
            if (c_bead_end) begin
                r_dof <= c_dof_end ? '0 : r_dof + 1'b1;
            end
        end
    end

    // Load request capture.
    logic               r_ld_ok;
    logic [AW-1:0]      r_ld_addr;
    logic signed [31:0] r_ld_x, r_ld_p;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_ld_ok   <= (32'(i_dof_index) < DOFS) && (32'(i_bead_index) < BEADS);
            r_ld_addr <= AW'(32'(i_dof_index) * BEADS + 32'(i_bead_index));
            r_ld_x    <= i_load_position;
            r_ld_p    <= i_load_momentum;
        end
    end

    // Working registers.
    logic signed [31:0] r_x, r_p, r_v, r_rn, r_rp, r_d, r_dx, r_kd, r_kx;
    logic signed [31:0] r_ks, r_ke, r_dt2, r_t;
    logic [30:0]        r_kin, r_pot;

    // Bead stores.
    logic          c_x_we, c_p_we, c_f_we;
    logic [AW-1:0] c_x_waddr, c_p_waddr, c_x_raddr;
    logic signed [31:0] c_x_wdata, c_p_wdata, c_f_wdata;
    logic signed [31:0] c_xrd, c_prd, c_frd_raw, c_frd;
    logic [NSLOTS-1:0]  r_fvld;
    logic               r_fv_q;

    assign c_x_we    = (i_cmd.uop == U_LOAD && r_ld_ok) || i_cmd.uop == U_DR_WR;
    assign c_x_waddr = (i_cmd.uop == U_LOAD) ? r_ld_addr : c_cur;
    assign c_x_wdata = (i_cmd.uop == U_LOAD) ? r_ld_x
                     : sat32(35'(r_x) + 35'(r_t));
    assign c_p_we    = (i_cmd.uop == U_LOAD && r_ld_ok) || i_cmd.uop == U_KI_WR;
    assign c_p_waddr = (i_cmd.uop == U_LOAD) ? r_ld_addr : c_cur;
    assign c_p_wdata = (i_cmd.uop == U_LOAD) ? r_ld_p
                     : sat32(35'(r_p) + 35'(r_t));
    assign c_f_we    = (i_cmd.uop == U_FO_WR);
    assign c_f_wdata = sat32(35'(sat32(-35'(r_kd))) + 35'(sat32(-35'(r_kx))));
    assign c_x_raddr = (i_cmd.uop == U_FO_RN) ? c_nx
                     : (i_cmd.uop == U_FO_RP) ? c_pv : c_cur;

    rpvs_ram #(.WIDTH(32), .DEPTH(NSLOTS)) u_pos (
        .i_clk   (i_clk),
        .i_we    (c_x_we),
        .i_waddr (c_x_waddr),
        .i_wdata (c_x_wdata),
        .i_raddr (c_x_raddr),
        .o_rdata (c_xrd)
    );

    rpvs_ram #(.WIDTH(32), .DEPTH(NSLOTS)) u_mom (
        .i_clk   (i_clk),
        .i_we    (c_p_we),
        .i_waddr (c_p_waddr),
        .i_wdata (c_p_wdata),
        .i_raddr (c_cur),
        .o_rdata (c_prd)
    );

    rpvs_ram #(.WIDTH(32), .DEPTH(NSLOTS)) u_force (
        .i_clk   (i_clk),
        .i_we    (c_f_we),
        .i_waddr (c_cur),
        .i_wdata (c_f_wdata),
        .i_raddr (c_cur),
        .o_rdata (c_frd_raw)
    );

    // Forces read as zero until first written after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= '0;
        end else if (c_f_we) begin
            r_fvld[c_cur] <= 1'b1;
        end
        r_fv_q <= r_fvld[c_cur];
    end
    assign c_frd = r_fv_q ? c_frd_raw : 32'sd0;

    // Shared multiplier: operand select, registered magnitude product,
    // then rounding and saturation registered into r_t.
    logic signed [31:0] c_ma, c_mb;
    logic               c_mul_en;
    logic [31:0]        c_abs_a, c_abs_b;
    logic [63:0]        r_prod, c_rnd;
    logic               r_neg;
    logic signed [31:0] c_mres;

    always_comb begin
        c_mul_en = 1'b1;
        c_ma     = 32'sd0;
        c_mb     = 32'sd0;
        case (i_cmd.uop)
            U_SU_MKS: begin c_ma = c_m;   c_mb = c_wp2;     end
            U_SU_MKE: begin c_ma = c_m;   c_mb = c_w2;      end
            U_SU_MDT: begin c_ma = c_dt;  c_mb = C_HALF;    end
            U_KI_MUL: begin c_ma = c_frd; c_mb = r_dt2;     end
            U_DR_MV:  begin c_ma = c_prd; c_mb = c_inv;     end
            U_DR_MPP: begin c_ma = r_p;   c_mb = r_p;       end
            U_DR_MQ:  begin c_ma = r_t;   c_mb = c_inv;     end
            U_DR_MY:  begin c_ma = r_v;   c_mb = c_dt;      end
            U_DR_MH:  begin c_ma = r_t;   c_mb = C_HALF;    end
            U_FO_MKD: begin c_ma = r_ks;  c_mb = r_d;       end
            U_FO_MKX: begin c_ma = r_ke;  c_mb = r_dx;      end
            U_FO_KD:  begin c_ma = r_t;   c_mb = r_d;       end
            U_FO_KX:  begin c_ma = r_t;   c_mb = r_dx;      end
            U_FO_MQ:  begin c_ma = r_t;   c_mb = C_QUARTER; end
            U_FO_MH:  begin c_ma = r_t;   c_mb = C_HALF;    end
            default:  c_mul_en = 1'b0;
        endcase
    end

    assign c_abs_a = c_ma[31] ? 32'(-c_ma) : 32'(c_ma);
    assign c_abs_b = c_mb[31] ? 32'(-c_mb) : 32'(c_mb);
    assign c_rnd   = (r_prod + RND_ULP) >> FRAC_BITS;

    always_comb begin
        if (!r_neg) begin
            c_mres = (c_rnd > 64'h7fffffff) ? 32'sh7fffffff : c_rnd[31:0];
        end else begin
            c_mres = (c_rnd > 64'h80000000) ? 32'sh80000000 : -c_rnd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_mul_en) begin
            r_prod <= 64'(c_abs_a) * 64'(c_abs_b);
            r_neg  <= c_ma[31] ^ c_mb[31];
        end
        r_t <= c_mres;
    end

    // Operand captures for each micro-step.
    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            U_SU_MDT: r_ks  <= r_t;
            U_SU_KE:  r_ke  <= r_t;
            U_SU_DT2: r_dt2 <= r_t;
            U_KI_MUL: r_p   <= c_prd;
            U_DR_MV: begin
                r_p <= c_prd;
                r_x <= c_xrd;
            end
            U_DR_V:   r_v   <= r_t;
            U_FO_RP:  r_rn  <= c_xrd;
            U_FO_LP:  r_rp  <= c_xrd;
            U_FO_LX: begin
                r_x  <= c_xrd;
                r_d  <= sat32(35'(c_xrd) + 35'(c_xrd) - 35'(r_rn) - 35'(r_rp));
                r_dx <= sat32(35'(c_xrd) - 35'(r_req));
            end
            U_FO_KD:  r_kd  <= r_t;
            U_FO_KX:  r_kx  <= r_t;
            default: ;
        endcase
    end

    // Energy accumulators.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kin <= '0;
            r_pot <= '0;
        end else begin
            case (i_cmd.uop)
                U_DR_ACC: r_kin <= eadd(r_kin, r_t);
                U_FO_ACC: r_pot <= eadd(r_pot, r_t);
                U_FO_WR:  r_pot <= eadd(r_pot, r_t);
                default: ;
            endcase
        end
    end

    // Bead 0 shadow for the probe outputs.
    logic signed [31:0] r_probe_x, r_probe_p;

    always_ff @(posedge i_clk) begin
        if (c_x_we && c_x_waddr == '0) begin
            r_probe_x <= c_x_wdata;
        end
        if (c_p_we && c_p_waddr == '0) begin
            r_probe_p <= c_p_wdata;
        end
    end

    // Result register.
    logic [31:0] c_tot;
    assign c_tot = {1'b0, r_kin} + {1'b0, r_pot};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_kinetic_energy   <= r_kin;
            o_potential_energy <= r_pot;
            o_total_energy     <= c_tot[31] ? 31'h7fffffff : c_tot[30:0];
            o_probe_position   <= r_probe_x;
            o_probe_momentum   <= r_probe_p;
        end
    end

endmodule

FILE: src/ring_polymer_verlet_step_core.sv
// Ring-polymer velocity-Verlet integrator, fixed point.
// Input channel (i_in_valid / o_in_ready): one request carries an action.
// A load request stores one bead's position and momentum; a prepare request
// computes all bead forces; a step request runs kick, drift with kinetic
// energy, force update with potential energy, and a second kick.
// Output channel (o_out_valid / i_out_ready): one result per request with
// the energies and bead 0 of the first ring.
// The block has one shared 32x32 multiplier and one read port per bead
// store; a new request is taken only after the previous one has reached
// the result register. The configuration port (i_cfg_we, i_cfg_index,
// i_cfg_data) writes one register per cycle; the user must see that it is
// used only while the block is idle, as the block itself does not enforce
// this.
// Reset restores the register defaults and clears all bead forces; bead
// positions and momenta must be loaded before use.
// When the receiver stalls the result waits in its register; the block may
// take and work on one more request meanwhile, then holds until it drains.
module ring_polymer_verlet_step_core import rpvs_pkg::*; #(
    parameter int BEADS     = 32,
    parameter int DOFS      = 2,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic               i_dof_index,
    input  logic [4:0]         i_bead_index,
    input  logic signed [31:0] i_load_position,
    input  logic signed [31:0] i_load_momentum,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [30:0]        o_kinetic_energy,
    output logic [30:0]        o_potential_energy,
    output logic [30:0]        o_total_energy,
    output logic signed [31:0] o_probe_position,
    output logic signed [31:0] o_probe_momentum
);

    t_cmd  c_cmd;
    t_stat c_stat;

    rpvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (c_cmd),
        .i_stat      (c_stat)
    );

    rpvs_dpath #(
        .BEADS     (BEADS),
        .DOFS      (DOFS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_dof_index        (i_dof_index),
        .i_bead_index       (i_bead_index),
        .i_load_position    (i_load_position),
        .i_load_momentum    (i_load_momentum),
        .i_cmd              (c_cmd),
        .o_stat             (c_stat),
        .o_kinetic_energy   (o_kinetic_energy),
        .o_potential_energy (o_potential_energy),
        .o_total_energy     (o_total_energy),
        .o_probe_position   (o_probe_position),
        .o_probe_momentum   (o_probe_momentum)
    );

endmodule
